// ===== sv/mtrs_pkg.sv =====
// Package for the modular target residue sweep: widths, payload structs and
// the micro-operation table that drives the shared multiply-reduce unit.
// No dependencies.
`default_nettype none

package mtrs_pkg;

  localparam int RESIDUE_WIDTH = 16;
  localparam int RW            = RESIDUE_WIDTH;
  // Widest dividend of the reduction unit: a product of two residues plus an addend.
  localparam int REM_W         = 2 * RW + 1;
  // Widest dividend of a small-constant operation: k * x + z with k below 8.
  localparam int SMALL_W       = RW + 4;
  localparam int SH_W          = $clog2(REM_W);
  localparam int BL_W          = $clog2(RW + 1);
  // Bezout coefficients of the inverse stay within plus or minus p.
  localparam int TRM_W         = RW + 2;
  localparam int MUL_W         = RW + 1 + TRM_W;
  localparam int PC_W          = 5;

  localparam logic [RW-1:0] MIN_MODULUS = RW'(5);

  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // Operand sources of a micro-operation.
  localparam logic [3:0] SRC_A  = 4'd0;
  localparam logic [3:0] SRC_T  = 4'd1;
  localparam logic [3:0] SRC_W  = 4'd2;
  localparam logic [3:0] SRC_AI = 4'd3;
  localparam logic [3:0] SRC_B  = 4'd4;
  localparam logic [3:0] SRC_C  = 4'd5;
  localparam logic [3:0] SRC_D  = 4'd6;
  localparam logic [3:0] SRC_E  = 4'd7;
  localparam logic [3:0] SRC_F  = 4'd8;
  localparam logic [3:0] SRC_K  = 4'd9;

  // Addend of a micro-operation.
  localparam logic [1:0] ADD_ZERO  = 2'd0;
  localparam logic [1:0] ADD_U     = 2'd1;
  localparam logic [1:0] ADD_NEG_U = 2'd2;
  localparam logic [1:0] ADD_W     = 2'd3;

  // Destination of a micro-operation.
  localparam logic [1:0] DST_T  = 2'd0;
  localparam logic [1:0] DST_U  = 2'd1;
  localparam logic [1:0] DST_W  = 2'd2;
  localparam logic [1:0] DST_R1 = 2'd3;

  localparam logic [PC_W-1:0] UOP_LAST_PC = PC_W'(24);
  localparam logic [PC_W-1:0] UOP_ECHK_PC = PC_W'(25);

  typedef struct packed {
    logic          op;
    logic [RW-1:0] coef_b;
    logic [RW-1:0] coef_c;
    logic [RW-1:0] coef_d;
    logic [RW-1:0] coef_e;
    logic [RW-1:0] coef_f;
  } in_item_t;

  typedef struct packed {
    logic          ok;
    logic [RW-1:0] sweep_value;
    logic [RW-1:0] target_modulus;
    logic [RW-1:0] first_residue;
    logic [RW-1:0] second_residue;
  } out_item_t;

  // dst = (x * y + addend) mod p; wide marks a full product.
  typedef struct packed {
    logic [3:0] x_src;
    logic [3:0] y_src;
    logic [2:0] k;
    logic [1:0] add;
    logic [1:0] dst;
    logic       wide;
  } uop_t;

  function automatic uop_t mk_uop(input logic [3:0] x, input logic [3:0] y,
                                  input logic [2:0] k, input logic [1:0] add,
                                  input logic [1:0] dst, input logic wide);
    uop_t u;
    u.x_src = x;
    u.y_src = y;
    u.k     = k;
    u.add   = add;
    u.dst   = dst;
    u.wide  = wide;
    return u;
  endfunction

  // Both targets are evaluated by Horner's rule in a, with the inverse terms
  // added at the end. The last entry reduces e on a start beat.
  function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
    uop_t u;
    unique case (pc)
      PC_W'(0):  u = mk_uop(SRC_B,  SRC_K,  3'd5, ADD_ZERO,  DST_U,  1'b0);
      PC_W'(1):  u = mk_uop(SRC_A,  SRC_K,  3'd6, ADD_NEG_U, DST_T,  1'b0);
      PC_W'(2):  u = mk_uop(SRC_F,  SRC_K,  3'd4, ADD_ZERO,  DST_U,  1'b0);
      PC_W'(3):  u = mk_uop(SRC_T,  SRC_A,  3'd0, ADD_U,     DST_T,  1'b1);
      PC_W'(4):  u = mk_uop(SRC_C,  SRC_K,  3'd3, ADD_ZERO,  DST_U,  1'b0);
      PC_W'(5):  u = mk_uop(SRC_T,  SRC_A,  3'd0, ADD_NEG_U, DST_T,  1'b1);
      PC_W'(6):  u = mk_uop(SRC_D,  SRC_K,  3'd2, ADD_ZERO,  DST_U,  1'b0);
      PC_W'(7):  u = mk_uop(SRC_T,  SRC_A,  3'd0, ADD_U,     DST_T,  1'b1);
      PC_W'(8):  u = mk_uop(SRC_T,  SRC_A,  3'd0, ADD_ZERO,  DST_T,  1'b1);
      PC_W'(9):  u = mk_uop(SRC_AI, SRC_AI, 3'd0, ADD_ZERO,  DST_W,  1'b1);
      PC_W'(10): u = mk_uop(SRC_W,  SRC_E,  3'd0, ADD_ZERO,  DST_W,  1'b1);
      PC_W'(11): u = mk_uop(SRC_T,  SRC_K,  3'd1, ADD_W,     DST_R1, 1'b0);
      PC_W'(12): u = mk_uop(SRC_B,  SRC_K,  3'd4, ADD_ZERO,  DST_U,  1'b0);
      PC_W'(13): u = mk_uop(SRC_A,  SRC_K,  3'd5, ADD_NEG_U, DST_T,  1'b0);
      PC_W'(14): u = mk_uop(SRC_F,  SRC_K,  3'd3, ADD_ZERO,  DST_U,  1'b0);
      PC_W'(15): u = mk_uop(SRC_T,  SRC_A,  3'd0, ADD_U,     DST_T,  1'b1);
      PC_W'(16): u = mk_uop(SRC_C,  SRC_K,  3'd2, ADD_ZERO,  DST_U,  1'b0);
      PC_W'(17): u = mk_uop(SRC_T,  SRC_A,  3'd0, ADD_NEG_U, DST_T,  1'b1);
      PC_W'(18): u = mk_uop(SRC_D,  SRC_K,  3'd1, ADD_ZERO,  DST_U,  1'b0);
      PC_W'(19): u = mk_uop(SRC_T,  SRC_A,  3'd0, ADD_U,     DST_T,  1'b1);
      PC_W'(20): u = mk_uop(SRC_T,  SRC_A,  3'd0, ADD_ZERO,  DST_T,  1'b1);
      PC_W'(21): u = mk_uop(SRC_T,  SRC_A,  3'd0, ADD_ZERO,  DST_T,  1'b1);
      PC_W'(22): u = mk_uop(SRC_E,  SRC_K,  3'd2, ADD_ZERO,  DST_W,  1'b0);
      PC_W'(23): u = mk_uop(SRC_W,  SRC_AI, 3'd0, ADD_ZERO,  DST_W,  1'b1);
      PC_W'(24): u = mk_uop(SRC_T,  SRC_K,  3'd1, ADD_W,     DST_T,  1'b0);
      PC_W'(25): u = mk_uop(SRC_E,  SRC_K,  3'd1, ADD_ZERO,  DST_U,  1'b0);
      default:   u = mk_uop(SRC_A,  SRC_K,  3'd0, ADD_ZERO,  DST_U,  1'b0);
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

// ===== sv/modular_target_residue_sweep.sv =====
// Top level of the modular target residue sweep: sequencer, Euclid inverse and
// one shared multiplier with a shift-subtract reduction unit. Uses mtrs_pkg.
//
//   channel  direction  handshake            payload
//   cfg_     in         cfg_we               cfg_wdata (prime modulus)
//   in_      in         in_valid / in_ready  in_data  (in_item_t)
//   out_     out        out_valid / out_ready out_data (out_item_t)
//
// One beat is worked on at a time; in_ready is high only while the sequencer idles.
// Each micro-operation runs S_MUL, S_ADD, the S_DIV shift-subtract loop and S_WB; a full
// product aligns the divisor higher than a small-constant one. An evaluation runs 12 + 13
// of them; a Euclid step runs S_INV_TEST, the S_DIV loop, S_INV_MUL and S_INV_UPD. A start
// first reduces e and ends if it is zero; an exhausted advance goes straight to S_DONE.
// rst_n is synchronous; a result waits in S_DONE while out_valid stalls.
`default_nettype none

module modular_target_residue_sweep import mtrs_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      cfg_we,
  input  wire logic [RW-1:0] cfg_wdata,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_MUL      = 4'd1;
  localparam logic [3:0] S_ADD      = 4'd2;
  localparam logic [3:0] S_DIV      = 4'd3;
  localparam logic [3:0] S_WB       = 4'd4;
  localparam logic [3:0] S_ECHK     = 4'd5;
  localparam logic [3:0] S_INV_TEST = 4'd6;
  localparam logic [3:0] S_INV_MUL  = 4'd7;
  localparam logic [3:0] S_INV_UPD  = 4'd8;
  localparam logic [3:0] S_INV_FIN  = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  function automatic logic [BL_W-1:0] bit_len(input logic [RW-1:0] v);
    logic [BL_W-1:0] n;
    n = '0;
    for (int i = 0; i < RW; i++) begin
      if (v[i]) begin
        n = BL_W'(i + 1);
      end
    end
    return n;
  endfunction

  // Control state.
  logic [3:0]       state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             exh_r, exh_nxt;
  logic [RW-1:0]    a_r, a_nxt;
  logic [RW-1:0]    cfg_p_r, cfg_p_nxt;
  logic             div_inv_r, div_inv_nxt;

  // Datapath.
  out_item_t        out_r, out_nxt;
  out_item_t        res_r, res_nxt;
  logic [RW-1:0]    cb_r, cb_nxt, cc_r, cc_nxt, cd_r, cd_nxt, ce_r, ce_nxt, cf_r, cf_nxt;
  logic [PC_W-1:0]  pc_r, pc_nxt;
  logic [RW-1:0]    t_r, t_nxt, u_r, u_nxt, w_r, w_nxt, ai_r, ai_nxt, fr_r, fr_nxt;
  logic signed [MUL_W-1:0] prod_r, prod_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt, dsh_r, dsh_nxt;
  logic [SH_W-1:0]  sh_r, sh_nxt;
  logic [RW-1:0]    quo_r, quo_nxt;
  logic [RW-1:0]    eu_r0_r, eu_r0_nxt, eu_r1_r, eu_r1_nxt;
  logic signed [TRM_W-1:0] eu_t0_r, eu_t0_nxt, eu_t1_r, eu_t1_nxt;

  logic [RW-1:0]    p_eff;
  logic [BL_W-1:0]  bl_p;
  uop_t             uop;
  logic [RW-1:0]    mop_x, mop_y, addend;
  logic signed [RW:0]      mul_a;
  logic signed [TRM_W-1:0] mul_b;
  logic signed [MUL_W-1:0] mul_p;
  logic [REM_W:0]   div_diff;
  logic             div_take;
  logic [SH_W-1:0]  op_sh, inv_sh;
  logic [RW:0]      a_inc;
  logic signed [TRM_W-1:0] t0_adj;
  logic             in_fire;

  assign p_eff    = (cfg_p_r < MIN_MODULUS) ? MIN_MODULUS : cfg_p_r;
  assign bl_p     = bit_len(p_eff);
  assign uop      = uop_rom(pc_r);
  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    unique case (uop.x_src)
      SRC_A:   mop_x = a_r;
      SRC_T:   mop_x = t_r;
      SRC_W:   mop_x = w_r;
      SRC_AI:  mop_x = ai_r;
      SRC_B:   mop_x = cb_r;
      SRC_C:   mop_x = cc_r;
      SRC_D:   mop_x = cd_r;
      SRC_E:   mop_x = ce_r;
      SRC_F:   mop_x = cf_r;
      default: mop_x = RW'(uop.k);
    endcase
  end

  always_comb begin
    unique case (uop.y_src)
      SRC_A:   mop_y = a_r;
      SRC_T:   mop_y = t_r;
      SRC_W:   mop_y = w_r;
      SRC_AI:  mop_y = ai_r;
      SRC_B:   mop_y = cb_r;
      SRC_C:   mop_y = cc_r;
      SRC_D:   mop_y = cd_r;
      SRC_E:   mop_y = ce_r;
      SRC_F:   mop_y = cf_r;
      default: mop_y = RW'(uop.k);
    endcase
  end

  always_comb begin
    unique case (uop.add)
      ADD_ZERO:  addend = '0;
      ADD_U:     addend = u_r;
      ADD_NEG_U: addend = p_eff - u_r;
      default:   addend = w_r;
    endcase
  end

  // The one multiplier serves both the residue products and the Euclid update.
  always_comb begin
    if (state_r == S_INV_MUL) begin
      mul_a = $signed({1'b0, quo_r});
      mul_b = eu_t1_r;
    end else begin
      mul_a = $signed({1'b0, mop_x});
      mul_b = $signed({2'b00, mop_y});
    end
  end
  assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);

  assign div_diff = {1'b0, rem_r} - {1'b0, dsh_r};
  assign div_take = !div_diff[REM_W];

  // The divisor starts just above the largest possible dividend.
  assign op_sh  = uop.wide ? (SH_W'(REM_W) - SH_W'(bl_p))
                           : (SH_W'(SMALL_W) - SH_W'(bl_p));
  assign inv_sh = SH_W'(bit_len(eu_r0_r)) - SH_W'(bit_len(eu_r1_r));
  assign a_inc  = {1'b0, a_r} + (RW + 1)'(1);
  assign t0_adj = eu_t0_r[TRM_W-1] ? (eu_t0_r + $signed({2'b00, p_eff})) : eu_t0_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    exh_nxt       = exh_r;
    a_nxt         = a_r;
    cfg_p_nxt     = cfg_we ? cfg_wdata[RW-1:0] : cfg_p_r;
    div_inv_nxt   = div_inv_r;
    out_nxt       = out_r;
    res_nxt       = res_r;
    cb_nxt        = cb_r;
    cc_nxt        = cc_r;
    cd_nxt        = cd_r;
    ce_nxt        = ce_r;
    cf_nxt        = cf_r;
    pc_nxt        = pc_r;
    t_nxt         = t_r;
    u_nxt         = u_r;
    w_nxt         = w_r;
    ai_nxt        = ai_r;
    fr_nxt        = fr_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    dsh_nxt       = dsh_r;
    sh_nxt        = sh_r;
    quo_nxt       = quo_r;
    eu_r0_nxt     = eu_r0_r;
    eu_r1_nxt     = eu_r1_r;
    eu_t0_nxt     = eu_t0_r;
    eu_t1_nxt     = eu_t1_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data.op == OP_START) begin
            cb_nxt    = in_data.coef_b;
            cc_nxt    = in_data.coef_c;
            cd_nxt    = in_data.coef_d;
            ce_nxt    = in_data.coef_e;
            cf_nxt    = in_data.coef_f;
            exh_nxt   = 1'b0;
            pc_nxt    = UOP_ECHK_PC;
            state_nxt = S_MUL;
          end else if (exh_r) begin
            res_nxt   = '{ok: 1'b0, sweep_value: a_r, target_modulus: p_eff,
                          first_residue: '0, second_residue: '0};
            state_nxt = S_DONE;
          end else if (a_inc >= {1'b0, p_eff}) begin
            a_nxt     = p_eff;
            exh_nxt   = 1'b1;
            res_nxt   = '{ok: 1'b0, sweep_value: p_eff, target_modulus: p_eff,
                          first_residue: '0, second_residue: '0};
            state_nxt = S_DONE;
          end else begin
            a_nxt     = a_inc[RW-1:0];
            eu_r0_nxt = p_eff;
            eu_r1_nxt = a_inc[RW-1:0];
            eu_t0_nxt = '0;
            eu_t1_nxt = TRM_W'(1);
            state_nxt = S_INV_TEST;
          end
        end
      end
      S_MUL: begin
        prod_nxt  = mul_p;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        rem_nxt     = prod_r[REM_W-1:0] + REM_W'(addend);
        dsh_nxt     = REM_W'(p_eff) << op_sh;
        sh_nxt      = op_sh;
        quo_nxt     = '0;
        div_inv_nxt = 1'b0;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        if (div_take) begin
          rem_nxt = div_diff[REM_W-1:0];
        end
        quo_nxt = {quo_r[RW-2:0], div_take};
        dsh_nxt = dsh_r >> 1;
        if (sh_r == '0) begin
          state_nxt = div_inv_r ? S_INV_MUL : S_WB;
        end else begin
          sh_nxt = sh_r - SH_W'(1);
        end
      end
      S_WB: begin
        unique case (uop.dst)
          DST_T:   t_nxt  = rem_r[RW-1:0];
          DST_U:   u_nxt  = rem_r[RW-1:0];
          DST_W:   w_nxt  = rem_r[RW-1:0];
          default: fr_nxt = rem_r[RW-1:0];
        endcase
        if (pc_r == UOP_ECHK_PC) begin
          state_nxt = S_ECHK;
        end else if (pc_r == UOP_LAST_PC) begin
          res_nxt   = '{ok: 1'b1, sweep_value: a_r, target_modulus: p_eff,
                        first_residue: fr_r, second_residue: rem_r[RW-1:0]};
          state_nxt = S_DONE;
        end else begin
          pc_nxt    = pc_r + PC_W'(1);
          state_nxt = S_MUL;
        end
      end
      S_ECHK: begin
        if (u_r == '0) begin
          // A start whose e vanishes modulo p sits at a = 0 with modulus one.
          a_nxt     = '0;
          res_nxt   = '{ok: 1'b1, sweep_value: '0, target_modulus: RW'(1),
                        first_residue: '0, second_residue: '0};
          state_nxt = S_DONE;
        end else begin
          a_nxt     = RW'(1);
          eu_r0_nxt = p_eff;
          eu_r1_nxt = RW'(1);
          eu_t0_nxt = '0;
          eu_t1_nxt = TRM_W'(1);
          state_nxt = S_INV_TEST;
        end
      end
      S_INV_TEST: begin
        if (eu_r1_r == '0) begin
          state_nxt = S_INV_FIN;
        end else begin
          rem_nxt     = REM_W'(eu_r0_r);
          dsh_nxt     = REM_W'(eu_r1_r) << inv_sh;
          sh_nxt      = inv_sh;
          quo_nxt     = '0;
          div_inv_nxt = 1'b1;
          state_nxt   = S_DIV;
        end
      end
      S_INV_MUL: begin
        prod_nxt  = mul_p;
        state_nxt = S_INV_UPD;
      end
      S_INV_UPD: begin
        eu_r0_nxt = eu_r1_r;
        eu_r1_nxt = rem_r[RW-1:0];
        eu_t0_nxt = eu_t1_r;
        eu_t1_nxt = eu_t0_r - $signed(prod_r[TRM_W-1:0]);
        state_nxt = S_INV_TEST;
      end
      S_INV_FIN: begin
        // Without a unit gcd there is no inverse and it counts as zero.
        ai_nxt    = (eu_r0_r == RW'(1)) ? t0_adj[RW-1:0] : '0;
        pc_nxt    = '0;
        state_nxt = S_MUL;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      exh_r       <= 1'b1;
      a_r         <= '0;
      cfg_p_r     <= MIN_MODULUS;
      div_inv_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      exh_r       <= exh_nxt;
      a_r         <= a_nxt;
      cfg_p_r     <= cfg_p_nxt;
      div_inv_r   <= div_inv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r   <= out_nxt;
    res_r   <= res_nxt;
    cb_r    <= cb_nxt;
    cc_r    <= cc_nxt;
    cd_r    <= cd_nxt;
    ce_r    <= ce_nxt;
    cf_r    <= cf_nxt;
    pc_r    <= pc_nxt;
    t_r     <= t_nxt;
    u_r     <= u_nxt;
    w_r     <= w_nxt;
    ai_r    <= ai_nxt;
    fr_r    <= fr_nxt;
    prod_r  <= prod_nxt;
    rem_r   <= rem_nxt;
    dsh_r   <= dsh_nxt;
    sh_r    <= sh_nxt;
    quo_r   <= quo_nxt;
    eu_r0_r <= eu_r0_nxt;
    eu_r1_r <= eu_r1_nxt;
    eu_t0_r <= eu_t0_nxt;
    eu_t1_r <= eu_t1_nxt;
  end

  // The partial remainder never reaches twice the aligned divisor.
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> ({1'b0, rem_r} < {dsh_r, 1'b0}))
    else $error("reduction remainder out of range");

  // With p at least five the gcd of the inverse search is never zero.
  a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INV_FIN |-> eu_r0_r != '0)
    else $error("inverse search ended on zero gcd");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat accepted while busy");

  a_residue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.ok && out_data.target_modulus != RW'(1) |->
      out_data.first_residue < out_data.target_modulus &&
      out_data.second_residue < out_data.target_modulus)
    else $error("residue not reduced");

  a_exhausted_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.ok |->
      out_data.first_residue == '0 && out_data.second_residue == '0)
    else $error("exhausted result carries residues");

endmodule

`default_nettype wire
